// ----- design/dspg_pkg.sv -----
// ----------------------------------------------------------------------------
// dspg_pkg
// Shared types and constants for the dual servo pulse generator.
// ----------------------------------------------------------------------------
package dspg_pkg;

   localparam int unsigned WIDTH_BITS  = 8;
   localparam int unsigned COUNT_BITS  = 16;
   localparam int unsigned VALUE_BITS  = 16;
   localparam int unsigned CSR_IDX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 16;

   // Register reset values
   localparam logic [WIDTH_BITS-1:0] MIN_WIDTH_RESET = 8'd5;
   localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_RESET = 8'd25;
   localparam logic [COUNT_BITS-1:0] PERIOD_RESET    = 16'd200;
   // Midpoint of the min and max reset values
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET =
      WIDTH_BITS'((32'(MIN_WIDTH_RESET) + 32'(MAX_WIDTH_RESET)) / 2);

   // ADC full scale and pulse divisor
   localparam logic [9:0] ADC_FULL_SCALE = 10'd1023;
   // value / 200 == (value >> 3) / 25 == ((value >> 3) * 5243) >> 17
   localparam logic [12:0] PULSE_RECIP = 13'd5243;
   localparam int unsigned PULSE_SHIFT = 17;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_WIDTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_WIDTH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD    = 2'd2;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_SET_ADC   = 2'd1,
      CMD_SET_PULSE = 2'd2
   } cmd_type;

   // One step handed to the frame timer
   typedef struct packed {
      logic                  fire;
      cmd_type               command;
      logic                  channel;
      logic [WIDTH_BITS-1:0] width;
   } dspg_step_type;

endpackage

// ----- design/dual_servo_pulse_generator.sv -----
// An accepted request word passes the input stage and the output stage before its response word.
// Throughput: one word per cycle while the response side is not stalled; a new word enters while the response waits.
// The frame counter, width and level registers update in the second stage.
// Reset clears both stages, the counter and the levels, loads widths of 15
// and the register defaults min 5, max 25, period 200.
// ----------------------------------------------------------------------------
// dual_servo_pulse_generator
// Two-channel servo pulse generator: tick and width-set commands in, the two
// servo levels after each command out.
// ----------------------------------------------------------------------------
module dual_servo_pulse_generator (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_command,
   input  logic                               req_channel,
   input  logic [dspg_pkg::VALUE_BITS-1:0]    req_value,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_servo0_level,
   output logic                               rsp_servo1_level,
   // register write port
   input  logic                               csr_write,
   input  logic [dspg_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [dspg_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import dspg_pkg::*;

   // Configuration registers
   logic [WIDTH_BITS-1:0] min_width_ff;
   logic [WIDTH_BITS-1:0] max_width_ff;
   logic [COUNT_BITS-1:0] period_ff;

   // Input stage
   logic                  s1_valid_ff;
   logic [1:0]            s1_command_ff;
   logic                  s1_channel_ff;
   logic [VALUE_BITS-1:0] s1_value_ff;

   // Output stage
   logic                  rsp_valid_ff;
   logic                  rsp_level0_ff;
   logic                  rsp_level1_ff;

   logic                  rsp_free;
   logic                  s1_advance;
   logic                  req_take;
   logic [WIDTH_BITS-1:0] adc_width;
   logic [WIDTH_BITS-1:0] pulse_width;
   dspg_step_type         step;
   logic                  level0_in;
   logic                  level1_in;

   // The response slot frees when empty or when its word is taken this cycle.
   // The input stage moves into it whenever it frees, so stall only when both
   // stages are full and the response side is stalled.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && rsp_free;
   assign req_stall  = s1_valid_ff && !rsp_free;
   assign req_take   = req_valid && !req_stall;

   // Register writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= MIN_WIDTH_RESET;
         max_width_ff <= MAX_WIDTH_RESET;
         period_ff    <= PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_WIDTH: min_width_ff <= csr_data[WIDTH_BITS-1:0];
            CSR_MAX_WIDTH: max_width_ff <= csr_data[WIDTH_BITS-1:0];
            CSR_PERIOD:    period_ff    <= csr_data[COUNT_BITS-1:0];
            default: begin
               // no register here
            end
         endcase
      end
   end

   // Input stage: capture a word whenever the stage is empty or advancing
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_valid_ff || s1_advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff <= req_command;
         s1_channel_ff <= req_channel;
         s1_value_ff   <= req_value;
      end
   end

   // Both width maps run on the staged value; the command picks one
   dspg_width_map u_width_map (
      .value       (s1_value_ff),
      .min_width   (min_width_ff),
      .max_width   (max_width_ff),
      .adc_width   (adc_width),
      .pulse_width (pulse_width)
   );

   always_comb begin
      step.fire    = s1_advance;
      step.command = cmd_type'(s1_command_ff);
      step.channel = s1_channel_ff;
      step.width   = (step.command == CMD_SET_ADC) ? adc_width : pulse_width;
   end

   // Counter, widths and levels advance with the stage
   dspg_frame_timer u_frame_timer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .period    (period_ff),
      .level0_in (level0_in),
      .level1_in (level1_in)
   );

   // Output stage: load the new levels as the input stage advances, hold
   // while stalled, drop valid once taken with nothing behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_level0_ff <= level0_in;
         rsp_level1_ff <= level1_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_servo0_level = rsp_level0_ff;
   assign rsp_servo1_level = rsp_level1_ff;

endmodule

// ----- design/dspg_width_map.sv -----
// ----------------------------------------------------------------------------
// dspg_width_map
// Maps an ADC reading or a timer pulse length to a pulse width in ticks.
// ----------------------------------------------------------------------------
module dspg_width_map (
   input  logic [dspg_pkg::VALUE_BITS-1:0] value,
   input  logic [dspg_pkg::WIDTH_BITS-1:0] min_width,
   input  logic [dspg_pkg::WIDTH_BITS-1:0] max_width,
   output logic [dspg_pkg::WIDTH_BITS-1:0] adc_width,
   output logic [dspg_pkg::WIDTH_BITS-1:0] pulse_width
);
   import dspg_pkg::*;

   logic [9:0]              adc_sat;
   logic [WIDTH_BITS-1:0]   span;
   logic [17:0]             adc_prod;
   logic [7:0]              adc_q0;
   logic [10:0]             adc_rem;
   logic [7:0]              adc_quot;
   logic [8:0]              adc_sum;
   logic [25:0]             pulse_prod;
   logic [8:0]              pulse_quot;
   logic [8:0]              pulse_lo;
   logic [8:0]              pulse_hi;

   // ADC map: min + sat(v) * span / 1023
   always_comb begin
      adc_sat  = (value > VALUE_BITS'(ADC_FULL_SCALE)) ? ADC_FULL_SCALE : value[9:0];
      span     = (max_width >= min_width) ? (max_width - min_width) : '0;
      adc_prod = 18'(adc_sat) * 18'(span);
      // x = q0*1024 + lo = q0*1023 + (q0 + lo); remainder stays below 2*1023
      adc_q0   = adc_prod[17:10];
      adc_rem  = 11'(adc_prod[9:0]) + 11'(adc_q0);
      adc_quot = (adc_rem >= 11'(ADC_FULL_SCALE)) ? (adc_q0 + 8'd1) : adc_q0;
      adc_sum  = 9'(min_width) + 9'(adc_quot);
      adc_width = adc_sum[7:0];
   end

   // Pulse set: value / 200, clamp low first, then high
   always_comb begin
      pulse_prod = 26'(value[15:3]) * 26'(PULSE_RECIP);
      pulse_quot = pulse_prod[25:PULSE_SHIFT];
      pulse_lo   = (pulse_quot < 9'(min_width)) ? 9'(min_width) : pulse_quot;
      pulse_hi   = (pulse_lo > 9'(max_width)) ? 9'(max_width) : pulse_lo;
      pulse_width = pulse_hi[7:0];
   end

endmodule

// ----- design/dspg_frame_timer.sv -----
// ----------------------------------------------------------------------------
// dspg_frame_timer
// Frame counter, stored channel widths and output levels.
// ----------------------------------------------------------------------------
module dspg_frame_timer (
   input  logic                            clock,
   input  logic                            reset,
   input  dspg_pkg::dspg_step_type         step,
   input  logic [dspg_pkg::COUNT_BITS-1:0] period,
   output logic                            level0_in,
   output logic                            level1_in
);
   import dspg_pkg::*;

   logic [COUNT_BITS-1:0] frame_count_ff, frame_count_in;
   logic [WIDTH_BITS-1:0] width0_ff, width0_in;
   logic [WIDTH_BITS-1:0] width1_ff, width1_in;
   logic                  level0_ff, level1_ff;
   logic [COUNT_BITS-1:0] count_inc;

   always_comb begin
      frame_count_in = frame_count_ff;
      width0_in      = width0_ff;
      width1_in      = width1_ff;
      level0_in      = level0_ff;
      level1_in      = level1_ff;
      count_inc      = frame_count_ff + COUNT_BITS'(1);
      unique case (step.command)
         CMD_TICK: begin
            frame_count_in = count_inc;
            if (count_inc == COUNT_BITS'(1)) begin
               level0_in = 1'b1;
               level1_in = 1'b1;
            end
            if (count_inc >= COUNT_BITS'(width0_ff)) begin
               level0_in = 1'b0;
            end
            if (count_inc >= COUNT_BITS'(width1_ff)) begin
               level1_in = 1'b0;
            end
            if (count_inc >= period) begin
               frame_count_in = '0;
            end
         end
         CMD_SET_ADC, CMD_SET_PULSE: begin
            if (step.channel) begin
               width1_in = step.width;
            end else begin
               width0_in = step.width;
            end
         end
         default: begin
            // unused command: hold everything
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         width0_ff      <= WIDTH_RESET;
         width1_ff      <= WIDTH_RESET;
         level0_ff      <= 1'b0;
         level1_ff      <= 1'b0;
      end else if (step.fire) begin
         frame_count_ff <= frame_count_in;
         width0_ff      <= width0_in;
         width1_ff      <= width1_in;
         level0_ff      <= level0_in;
         level1_ff      <= level1_in;
      end
   end

endmodule

// ----- design/dspg_checker.sv -----
// ----------------------------------------------------------------------------
// dspg_checker
// Port-level checks for the dual servo pulse generator, bound to the top.
// ----------------------------------------------------------------------------
module dspg_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_servo0_level,
   input logic                               rsp_servo1_level
);

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_servo0_level) && $stable(rsp_servo1_level))
      else $error("response word changed while stalled");

   // Reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Request stall only comes from a stalled, full response side
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without response backpressure");

   // Accepting a word while no response is pending leads to a valid response after the input and output stages
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> ##1 rsp_valid)
      else $error("accepted word produced no response");

endmodule

bind dual_servo_pulse_generator dspg_checker u_dspg_checker (.*);
